[hdl/kst_pkg.sv]
// Package for the keyboard scan code translator.
// Holds the shared state and result types, the key codes and the ASCII tables.
// No dependencies.
package kst_pkg;

  localparam logic [7:0] PREFIX_E0 = 8'hE0;
  localparam logic [7:0] PREFIX_E1 = 8'hE1;

  localparam logic [6:0] KEY_ESC    = 7'h01;
  localparam logic [6:0] KEY_BKSP   = 7'h0E;
  localparam logic [6:0] KEY_TAB    = 7'h0F;
  localparam logic [6:0] KEY_ENTER  = 7'h1C;
  localparam logic [6:0] KEY_CTRL   = 7'h1D;
  localparam logic [6:0] KEY_LSHIFT = 7'h2A;
  localparam logic [6:0] KEY_SLASH  = 7'h35;
  localparam logic [6:0] KEY_RSHIFT = 7'h36;
  localparam logic [6:0] KEY_ALT    = 7'h38;
  localparam logic [6:0] KEY_SPACE  = 7'h39;
  localparam logic [6:0] KEY_CAPS   = 7'h3A;
  localparam logic [6:0] KEY_NUM    = 7'h45;
  localparam logic [6:0] KEY_SCROLL = 7'h46;
  localparam logic [6:0] KEY_PAD_LO = 7'h47;
  localparam logic [6:0] KEY_INS    = 7'h52;
  localparam logic [6:0] KEY_DEL    = 7'h53;
  localparam logic [6:0] TABLE_LEN  = 7'h36;

  localparam logic [15:0] WORD_PAD_ENTER = 16'hE00D;
  localparam logic [15:0] WORD_PAD_SLASH = 16'hE02F;
  localparam logic [7:0]  EXT_ASCII      = 8'hE0;

  // Bit positions in the shift state byte.
  localparam int unsigned F_RSHIFT = 0;
  localparam int unsigned F_LSHIFT = 1;
  localparam int unsigned F_CTRL   = 2;
  localparam int unsigned F_ALT    = 3;
  localparam int unsigned F_SCROLL = 4;
  localparam int unsigned F_NUM    = 5;
  localparam int unsigned F_CAPS   = 6;
  localparam int unsigned F_INS    = 7;

  typedef struct packed {
    logic [7:0] shift_state;
    logic       after_e0;
    logic       after_e1;
    logic       right_ctrl_down;
    logic       right_alt_down;
  } kst_state_t;

  typedef struct packed {
    logic [15:0] key_code;
    logic        key_valid;
    logic        flush_request;
    logic        reboot_request;
    logic [7:0]  modifier_flags;
  } kst_result_t;

  function automatic logic [7:0] plain_char(input logic [6:0] key);
    logic [7:0] c;
    case (key)
      7'h02: c = 8'h31; 7'h03: c = 8'h32; 7'h04: c = 8'h33; 7'h05: c = 8'h34;
      7'h06: c = 8'h35; 7'h07: c = 8'h36; 7'h08: c = 8'h37; 7'h09: c = 8'h38;
      7'h0A: c = 8'h39; 7'h0B: c = 8'h30; 7'h0C: c = 8'h2D; 7'h0D: c = 8'h3D;
      7'h10: c = 8'h71; 7'h11: c = 8'h77; 7'h12: c = 8'h65; 7'h13: c = 8'h72;
      7'h14: c = 8'h74; 7'h15: c = 8'h79; 7'h16: c = 8'h75; 7'h17: c = 8'h69;
      7'h18: c = 8'h6F; 7'h19: c = 8'h70; 7'h1A: c = 8'h5B; 7'h1B: c = 8'h5D;
      7'h1E: c = 8'h61; 7'h1F: c = 8'h73; 7'h20: c = 8'h64; 7'h21: c = 8'h66;
      7'h22: c = 8'h67; 7'h23: c = 8'h68; 7'h24: c = 8'h6A; 7'h25: c = 8'h6B;
      7'h26: c = 8'h6C; 7'h27: c = 8'h3B; 7'h28: c = 8'h27; 7'h29: c = 8'h60;
      7'h2B: c = 8'h5C; 7'h2C: c = 8'h7A; 7'h2D: c = 8'h78; 7'h2E: c = 8'h63;
      7'h2F: c = 8'h76; 7'h30: c = 8'h62; 7'h31: c = 8'h6E; 7'h32: c = 8'h6D;
      7'h33: c = 8'h2C; 7'h34: c = 8'h2E; 7'h35: c = 8'h2F;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] shift_char(input logic [6:0] key);
    logic [7:0] c;
    case (key)
      7'h02: c = 8'h21; 7'h03: c = 8'h40; 7'h04: c = 8'h23; 7'h05: c = 8'h24;
      7'h06: c = 8'h25; 7'h07: c = 8'h5E; 7'h08: c = 8'h26; 7'h09: c = 8'h2A;
      7'h0A: c = 8'h28; 7'h0B: c = 8'h29; 7'h0C: c = 8'h5F; 7'h0D: c = 8'h2B;
      7'h10: c = 8'h51; 7'h11: c = 8'h57; 7'h12: c = 8'h45; 7'h13: c = 8'h52;
      7'h14: c = 8'h54; 7'h15: c = 8'h59; 7'h16: c = 8'h55; 7'h17: c = 8'h49;
      7'h18: c = 8'h4F; 7'h19: c = 8'h50; 7'h1A: c = 8'h7B; 7'h1B: c = 8'h7D;
      7'h1E: c = 8'h41; 7'h1F: c = 8'h53; 7'h20: c = 8'h44; 7'h21: c = 8'h46;
      7'h22: c = 8'h47; 7'h23: c = 8'h48; 7'h24: c = 8'h4A; 7'h25: c = 8'h4B;
      7'h26: c = 8'h4C; 7'h27: c = 8'h3A; 7'h28: c = 8'h22; 7'h29: c = 8'h7E;
      7'h2B: c = 8'h7C; 7'h2C: c = 8'h5A; 7'h2D: c = 8'h58; 7'h2E: c = 8'h43;
      7'h2F: c = 8'h56; 7'h30: c = 8'h42; 7'h31: c = 8'h4E; 7'h32: c = 8'h4D;
      7'h33: c = 8'h3C; 7'h34: c = 8'h3E; 7'h35: c = 8'h3F;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic is_lower(input logic [7:0] c);
    return (c >= 8'h61) && (c <= 8'h7A);
  endfunction

  function automatic logic is_upper(input logic [7:0] c);
    return (c >= 8'h41) && (c <= 8'h5A);
  endfunction

  function automatic logic [7:0] to_ascii(input logic [6:0] key, input logic shift,
                                          input logic ctrl, input logic caps);
    logic [7:0] p;
    logic [7:0] c;
    p = plain_char(key);
    c = shift ? shift_char(key) : p;
    if (caps && is_lower(c)) begin
      c = c - 8'h20;
    end else if (caps && is_upper(c)) begin
      c = c + 8'h20;
    end
    if (key == KEY_ESC) c = 8'h1B;
    else if (key == KEY_BKSP) c = 8'h08;
    else if (key == KEY_TAB) c = 8'h09;
    else if (key == KEY_ENTER) c = 8'h0D;
    else if (key == KEY_SPACE) c = 8'h20;
    // Control combinations take precedence over everything above.
    if (ctrl) begin
      if (is_lower(p)) c = p - 8'h60;
      else if (key == KEY_ENTER) c = 8'h0A;
      else if (key == KEY_BKSP) c = 8'h7F;
    end
    return c;
  endfunction

endpackage

[hdl/kst_xlate.sv]
// Combinational translation of one keyboard byte against the current state.
// Depends on kst_pkg.
module kst_xlate import kst_pkg::*; (
  input  logic [7:0]  raw_code,
  input  logic        use_replacement,
  input  logic [7:0]  replacement_code,
  input  kst_state_t  state,
  output kst_state_t  state_next,
  output kst_result_t result
);

  logic [7:0]  code;
  logic [6:0]  key;
  logic        up;
  logic [7:0]  f;
  logic        handled;
  logic        reboot;
  logic        flush;
  logic        shift;
  logic [15:0] word;

  assign code = use_replacement ? replacement_code : raw_code;
  assign key  = code[6:0];
  assign up   = raw_code[7];

  always_comb begin
    state_next = state;
    f          = state.shift_state;
    handled    = 1'b0;
    reboot     = 1'b0;
    flush      = 1'b0;
    shift      = 1'b0;
    word       = 16'h0000;
    result     = '0;

    if ((raw_code == PREFIX_E0) || (raw_code == PREFIX_E1)) begin
      state_next.after_e0 = (raw_code == PREFIX_E0);
      state_next.after_e1 = (raw_code == PREFIX_E1);
    end else if (code != 8'h00) begin
      unique case (key)
        KEY_LSHIFT, KEY_RSHIFT: begin
          // A shift key behind E0 is a fake shift and leaves the flags alone.
          if (!state.after_e0) begin
            if (key == KEY_LSHIFT) f[F_LSHIFT] = !up;
            else f[F_RSHIFT] = !up;
            handled = 1'b1;
          end
        end
        KEY_CTRL: begin
          f[F_CTRL] = !up;
          if (state.after_e0) state_next.right_ctrl_down = !up;
          handled = 1'b1;
        end
        KEY_ALT: begin
          f[F_ALT] = !up;
          if (state.after_e0) state_next.right_alt_down = !up;
          handled = 1'b1;
        end
        KEY_CAPS: begin
          if (!up) f[F_CAPS] = !f[F_CAPS];
          handled = 1'b1;
        end
        KEY_NUM: begin
          // Behind E1 this is the Pause key.
          if (!state.after_e1 && !up) f[F_NUM] = !f[F_NUM];
          handled = 1'b1;
        end
        KEY_SCROLL: begin
          if (state.after_e0) flush = up;
          else if (!up) f[F_SCROLL] = !f[F_SCROLL];
          handled = 1'b1;
        end
        KEY_INS: begin
          if (!up && !state.after_e0) f[F_INS] = !f[F_INS];
        end
        KEY_DEL: begin
          if (!up && f[F_CTRL] && f[F_ALT]) begin
            reboot  = 1'b1;
            handled = 1'b1;
          end
        end
        default: begin
        end
      endcase

      if (!handled && !up) begin
        shift = f[F_LSHIFT] || f[F_RSHIFT];
        if (f[F_NUM] && (key >= KEY_PAD_LO) && (key <= KEY_DEL)) shift = !shift;
        word = {1'b0, key, to_ascii(key, shift, f[F_CTRL], f[F_CAPS])};
        if (state.after_e0) begin
          if (key == KEY_ENTER) word = WORD_PAD_ENTER;
          else if (key == KEY_SLASH) word = WORD_PAD_SLASH;
          else word = {word[15:8], EXT_ASCII};
        end
      end

      // The reboot combination keeps the prefix marks; every other key clears them.
      if (!reboot) begin
        state_next.after_e0 = 1'b0;
        state_next.after_e1 = 1'b0;
      end
    end

    state_next.shift_state = f;
    result.key_valid       = (word != 16'h0000);
    result.key_code        = word;
    result.flush_request   = flush;
    result.reboot_request  = reboot;
    result.modifier_flags  = f;
  end

endmodule

[hdl/keyboard_scancode_translator_top.sv]
// Top level of the keyboard scan code translator: input register, state, result register.
// Depends on kst_pkg and kst_xlate.

// Takes set-1 scan code bytes, one per transaction, and returns exactly one result per
// byte: a BIOS key word (scan code high, ASCII low) with its valid flag, the Ctrl+Break
// and Ctrl+Alt+Del requests, and the shift state byte left behind by that byte. A byte
// is accepted in every cycle in which in_stall is low; each accepted byte sits in the input
// register until the result register is free, then passes through the translation
// logic into the result register. The input register absorbs one more
// byte while a result waits under out_stall, so in_stall rises only when both registers
// are full.
module keyboard_scancode_translator_top import kst_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  raw_code,
  input  logic        use_replacement,
  input  logic [7:0]  replacement_code,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] key_code,
  output logic        key_valid,
  output logic        flush_request,
  output logic        reboot_request,
  output logic [7:0]  modifier_flags
);

  logic        hold_valid;
  logic [7:0]  hold_raw;
  logic        hold_use;
  logic [7:0]  hold_rep;
  kst_state_t  state;
  kst_state_t  state_next;
  kst_result_t result;
  logic        out_free;
  logic        advance;
  logic        in_take;

  assign out_free = !out_valid || !out_stall;
  assign advance  = hold_valid && out_free;
  assign in_stall = hold_valid && !out_free;
  assign in_take  = in_valid && !in_stall;

  kst_xlate u_xlate (
    .raw_code         (hold_raw),
    .use_replacement  (hold_use),
    .replacement_code (hold_rep),
    .state            (state),
    .state_next       (state_next),
    .result           (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      out_valid  <= 1'b0;
      state      <= '0;
    end else begin
      if (in_take) begin
        hold_valid <= 1'b1;
      end else if (advance) begin
        hold_valid <= 1'b0;
      end
      if (advance) begin
        out_valid <= 1'b1;
        state     <= state_next;
      end else if (out_free) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      hold_raw <= raw_code;
      hold_use <= use_replacement;
      hold_rep <= replacement_code;
    end
    if (advance) begin
      key_code       <= result.key_code;
      key_valid      <= result.key_valid;
      flush_request  <= result.flush_request;
      reboot_request <= result.reboot_request;
      modifier_flags <= result.modifier_flags;
    end
  end

endmodule

[hdl/kst_checker.sv]
// Port-level checks for the keyboard scan code translator, bound to its top level.
// Depends on keyboard_scancode_translator_top.
module kst_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] key_code,
  input logic        key_valid,
  input logic        flush_request,
  input logic        reboot_request
);

  // A result that is not queued carries a zero key word.
  a_zero_word: assert property (@(posedge clk) disable iff (rst)
    out_valid && !key_valid |-> key_code == 16'h0000)
    else $error("key_code not zero on a result without key_valid");

  // Reboot and flush never come with a queued key.
  a_no_key_on_request: assert property (@(posedge clk) disable iff (rst)
    out_valid && (reboot_request || flush_request) |-> !key_valid)
    else $error("key queued together with a reboot or flush request");

  // The input side backs up only behind a stalled result.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("in_stall raised while the result register can drain");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("result pending right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(key_code) && $stable(key_valid))
    else $error("stalled result changed");

endmodule

bind keyboard_scancode_translator_top kst_checker u_kst_checker (.*);

[dv/keyboard_scancode_translator_checker.sv]
// Result checker for the keyboard scan code translator testbench.
// Predicts the key word, requests and shift state of every accepted byte and compares them
// with the block's results in order. Depends on kst_pkg.
`timescale 1ns / 100ps

module keyboard_scancode_translator_checker import kst_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  raw_code,
  input  logic        use_replacement,
  input  logic [7:0]  replacement_code,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [15:0] key_code,
  input  logic        key_valid,
  input  logic        flush_request,
  input  logic        reboot_request,
  input  logic [7:0]  modifier_flags,
  output int          mismatches,
  output int          words_pending
);

  // Character rows indexed by key number; a blank marks a key with no character.
  string plain_row   = "  1234567890-=  qwertyuiop[]  asdfghjkl;'` \\zxcvbnm,./";
  string shifted_row = "  !@#$%^&*()_+  QWERTYUIOP{}  ASDFGHJKL:\"~ |ZXCVBNM<>?";

  kst_state_t  kbd;
  kst_result_t expected_words[$];

  initial begin
    mismatches = 0;
    words_pending = 0;
    kbd = '0;
  end

  function automatic logic [7:0] row_char(input logic [6:0] key, input logic shifted);
    logic [7:0] c;
    c = shifted ? 8'(shifted_row[key]) : 8'(plain_row[key]);
    return (c == 8'h20) ? 8'h00 : c;
  endfunction

  function automatic logic [7:0] key_ascii(input logic [6:0] key, input logic shifted,
                                           input logic ctrl, input logic caps);
    logic [7:0] c;
    if (ctrl) begin
      if (key < TABLE_LEN) begin
        c = row_char(key, 1'b0);
        if (c >= 8'h61 && c <= 8'h7A) return c - 8'h60;
      end
      if (key == KEY_ENTER) return 8'h0A;
      if (key == KEY_BKSP) return 8'h7F;
    end
    case (key)
      KEY_ESC:   return 8'h1B;
      KEY_BKSP:  return 8'h08;
      KEY_TAB:   return 8'h09;
      KEY_ENTER: return 8'h0D;
      KEY_SPACE: return 8'h20;
      default: ;
    endcase
    if (key >= TABLE_LEN) return 8'h00;
    c = row_char(key, shifted);
    if (caps && c >= 8'h61 && c <= 8'h7A) c = c - 8'h20;
    else if (caps && c >= 8'h41 && c <= 8'h5A) c = c + 8'h20;
    return c;
  endfunction

  // Advances the predicted keyboard state by one byte and returns the expected result.
  function automatic kst_result_t translate_byte(input logic [7:0] raw, input logic use_rep,
                                                 input logic [7:0] rep);
    logic [7:0]  code;
    logic        up;
    logic [6:0]  key;
    logic [7:0]  f;
    logic [15:0] word;
    logic        shifted;
    logic        valid;
    logic        flush;
    logic        reboot;
    logic        emit;
    logic        handled;
    kst_result_t r;
    code = use_rep ? rep : raw;
    up = raw[7];
    key = code[6:0];
    f = kbd.shift_state;
    word = '0;
    valid = 1'b0;
    flush = 1'b0;
    reboot = 1'b0;
    emit = 1'b1;
    handled = 1'b0;
    if (raw == PREFIX_E0 || raw == PREFIX_E1) begin
      kbd.after_e0 = (raw == PREFIX_E0);
      kbd.after_e1 = (raw == PREFIX_E1);
    end else if (code != 8'h00) begin
      case (key)
        KEY_LSHIFT, KEY_RSHIFT: begin
          // A shift after E0 is a fake shift and leaves the flags alone.
          if (!kbd.after_e0) begin
            if (key == KEY_LSHIFT) f[F_LSHIFT] = !up;
            else f[F_RSHIFT] = !up;
            handled = 1'b1;
          end
        end
        KEY_CTRL: begin
          f[F_CTRL] = !up;
          if (kbd.after_e0) kbd.right_ctrl_down = !up;
          handled = 1'b1;
        end
        KEY_ALT: begin
          f[F_ALT] = !up;
          if (kbd.after_e0) kbd.right_alt_down = !up;
          handled = 1'b1;
        end
        KEY_CAPS: begin
          if (!up) f[F_CAPS] = !f[F_CAPS];
          handled = 1'b1;
        end
        KEY_NUM: begin
          if (!kbd.after_e1 && !up) f[F_NUM] = !f[F_NUM];
          handled = 1'b1;
        end
        KEY_SCROLL: begin
          if (kbd.after_e0) flush = up;
          else if (!up) f[F_SCROLL] = !f[F_SCROLL];
          handled = 1'b1;
        end
        KEY_INS: begin
          if (!up && !kbd.after_e0) f[F_INS] = !f[F_INS];
        end
        KEY_DEL: begin
          if (!up && f[F_CTRL] && f[F_ALT]) begin
            reboot = 1'b1;
            handled = 1'b1;
            emit = 1'b0;
          end
        end
        default: ;
      endcase
      if (!handled && !up) begin
        shifted = f[F_LSHIFT] | f[F_RSHIFT];
        if (f[F_NUM] && key >= KEY_PAD_LO && key <= KEY_DEL) shifted = !shifted;
        word = {1'b0, key, key_ascii(key, shifted, f[F_CTRL], f[F_CAPS])};
        if (kbd.after_e0) begin
          if (key == KEY_ENTER) word = WORD_PAD_ENTER;
          else if (key == KEY_SLASH) word = WORD_PAD_SLASH;
          else word = {word[15:8], EXT_ASCII};
        end
        valid = (word != 16'h0000);
      end
      if (emit) begin
        kbd.after_e0 = 1'b0;
        kbd.after_e1 = 1'b0;
      end
    end
    kbd.shift_state = f;
    r.key_code = valid ? word : 16'h0000;
    r.key_valid = valid;
    r.flush_request = flush;
    r.reboot_request = reboot;
    r.modifier_flags = f;
    return r;
  endfunction

  task automatic note_mismatch(input string what, input kst_result_t want,
                               input kst_result_t seen);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: %s: expected key %h valid %b flush %b reboot %b flags %h,", $time, what,
               want.key_code, want.key_valid, want.flush_request, want.reboot_request,
               want.modifier_flags);
      $display("    got key %h valid %b flush %b reboot %b flags %h",
               seen.key_code, seen.key_valid, seen.flush_request, seen.reboot_request,
               seen.modifier_flags);
    end
  endtask

  // Results are handled before the byte of the same edge, which cannot produce them yet.
  always @(posedge clk) begin : watch
    kst_result_t seen;
    kst_result_t want;
    if (rst) begin
      kbd = '0;
      expected_words.delete();
    end else begin
      if (out_valid && !out_stall) begin
        seen = {key_code, key_valid, flush_request, reboot_request, modifier_flags};
        if (expected_words.size() == 0) begin
          note_mismatch("result with no transaction waiting", '0, seen);
        end else begin
          want = expected_words.pop_front();
          if (seen.key_code !== want.key_code || seen.key_valid !== want.key_valid ||
              seen.flush_request !== want.flush_request ||
              seen.reboot_request !== want.reboot_request ||
              seen.modifier_flags !== want.modifier_flags) begin
            note_mismatch("result differs", want, seen);
          end
        end
      end
      if (in_valid && !in_stall) begin
        expected_words.push_back(translate_byte(raw_code, use_replacement, replacement_code));
      end
    end
    words_pending = expected_words.size();
  end

endmodule

[dv/keyboard_scancode_translator_top_test.sv]
// Testbench top for the keyboard scan code translator: clock, reset, byte stimulus,
// receiver stalls and the verdict. Depends on kst_pkg, keyboard_scancode_translator_top
// and keyboard_scancode_translator_checker.
`timescale 1ns / 100ps

module keyboard_scancode_translator_top_test;
  import kst_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_BYTES = 1000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  raw_code = 8'h00;
  logic        use_replacement = 1'b0;
  logic [7:0]  replacement_code = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] key_code;
  logic        key_valid;
  logic        flush_request;
  logic        reboot_request;
  logic [7:0]  modifier_flags;

  int   mismatches;
  int   words_pending;
  int   gap_pct = 0;
  int   stall_pct = 0;
  int   bytes_sent = 0;
  int   cycles = 0;
  int   phase_end;
  logic byte_taken = 1'b0;

  initial begin
    forever #4 clk = ~clk;
  end

  keyboard_scancode_translator_top u_dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .raw_code         (raw_code),
    .use_replacement  (use_replacement),
    .replacement_code (replacement_code),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .key_code         (key_code),
    .key_valid        (key_valid),
    .flush_request    (flush_request),
    .reboot_request   (reboot_request),
    .modifier_flags   (modifier_flags)
  );

  keyboard_scancode_translator_checker u_checker (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .raw_code         (raw_code),
    .use_replacement  (use_replacement),
    .replacement_code (replacement_code),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .key_code         (key_code),
    .key_valid        (key_valid),
    .flush_request    (flush_request),
    .reboot_request   (reboot_request),
    .modifier_flags   (modifier_flags),
    .mismatches       (mismatches),
    .words_pending    (words_pending)
  );

  // Acceptance is captured at the rising edge and read by the driver at the falling edge.
  always @(posedge clk) begin
    byte_taken <= in_valid && !in_stall;
  end

  always @(negedge clk) begin
    out_stall <= !rst && ($urandom_range(0, 99) < stall_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] raw, input logic use_rep, input logic [7:0] rep);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    raw_code <= raw;
    use_replacement <= use_rep;
    replacement_code <= rep;
    do @(negedge clk); while (!byte_taken);
    bytes_sent++;
  endtask

  // One press or release, with an optional E0 prefix; now and then the hook replaces the
  // code, sometimes with zero so that the key is swallowed.
  task automatic key_stroke(input logic [6:0] key, input logic ext, input logic up);
    logic       hooked;
    logic [7:0] hook_code;
    hooked = ($urandom_range(0, 9) == 0);
    hook_code = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom);
    if (ext) send_byte(PREFIX_E0, 1'b0, 8'($urandom));
    send_byte({up, key}, hooked, hook_code);
  endtask

  function automatic logic [6:0] pick_key();
    if ($urandom_range(0, 9) < 8) return 7'($urandom_range(1, KEY_DEL));
    return 7'($urandom_range(0, 127));
  endfunction

  task automatic random_gesture();
    int         pick;
    logic [6:0] key;
    logic [6:0] modifier;
    logic       ext;
    logic       mod_ext;
    pick = $urandom_range(0, 99);
    key = pick_key();
    ext = ($urandom_range(0, 4) == 0);
    if (pick < 55) begin
      key_stroke(key, ext, 1'b0);
      if ($urandom_range(0, 3) != 0) key_stroke(key, ext, 1'b1);
    end else if (pick < 75) begin
      case ($urandom_range(0, 3))
        0:       modifier = KEY_LSHIFT;
        1:       modifier = KEY_RSHIFT;
        2:       modifier = KEY_CTRL;
        default: modifier = KEY_ALT;
      endcase
      mod_ext = ($urandom_range(0, 3) == 0);
      key_stroke(modifier, mod_ext, 1'b0);
      repeat ($urandom_range(1, 3)) begin
        key = pick_key();
        key_stroke(key, ext, 1'b0);
        key_stroke(key, ext, 1'b1);
      end
      key_stroke(modifier, mod_ext, 1'b1);
    end else if (pick < 83) begin
      key_stroke(KEY_CTRL, ext, 1'b0);
      key_stroke(KEY_ALT, 1'($urandom), 1'b0);
      key_stroke(KEY_DEL, 1'($urandom), 1'b0);
      key_stroke(KEY_DEL, 1'b0, 1'b1);
      key_stroke(KEY_ALT, 1'b0, 1'b1);
      key_stroke(KEY_CTRL, ext, 1'b1);
    end else if (pick < 86) begin
      // Pause key: E1 1D 45 E1 9D C5.
      send_byte(PREFIX_E1, 1'b0, 8'($urandom));
      send_byte({1'b0, KEY_CTRL}, 1'b0, 8'($urandom));
      send_byte({1'b0, KEY_NUM}, 1'b0, 8'($urandom));
      send_byte(PREFIX_E1, 1'b0, 8'($urandom));
      send_byte({1'b1, KEY_CTRL}, 1'b0, 8'($urandom));
      send_byte({1'b1, KEY_NUM}, 1'b0, 8'($urandom));
    end else if (pick < 90) begin
      key_stroke(KEY_CTRL, 1'b0, 1'b0);
      key_stroke(KEY_SCROLL, 1'b1, 1'b0);
      key_stroke(KEY_SCROLL, 1'b1, 1'b1);
      key_stroke(KEY_CTRL, 1'b0, 1'b1);
    end else begin
      send_byte(8'($urandom), 1'($urandom), 8'($urandom));
    end
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed opening: field extremes, prefixes, modifiers, lock keys and keypad keys.
    send_byte(8'h1E, 1'b0, 8'($urandom));
    send_byte(8'h9E, 1'b0, 8'($urandom));
    send_byte(8'h00, 1'b0, 8'($urandom));
    send_byte(8'hFF, 1'b0, 8'($urandom));
    send_byte(8'h7F, 1'b0, 8'($urandom));
    send_byte(8'h1E, 1'b1, 8'h00);
    send_byte(8'h10, 1'b1, 8'hFF);
    send_byte(PREFIX_E0, 1'b0, 8'($urandom));
    send_byte({1'b0, KEY_ENTER}, 1'b0, 8'($urandom));
    send_byte(PREFIX_E0, 1'b0, 8'($urandom));
    send_byte({1'b0, KEY_SLASH}, 1'b0, 8'($urandom));
    send_byte(PREFIX_E0, 1'b0, 8'($urandom));
    send_byte({1'b0, KEY_LSHIFT}, 1'b0, 8'($urandom));
    send_byte(PREFIX_E0, 1'b0, 8'($urandom));
    send_byte({1'b0, KEY_CTRL}, 1'b0, 8'($urandom));
    send_byte(PREFIX_E0, 1'b0, 8'($urandom));
    send_byte({1'b1, KEY_SCROLL}, 1'b0, 8'($urandom));
    send_byte(PREFIX_E1, 1'b0, 8'($urandom));
    send_byte({1'b0, KEY_NUM}, 1'b0, 8'($urandom));
    send_byte({1'b0, KEY_CAPS}, 1'b0, 8'($urandom));
    send_byte(8'h1E, 1'b0, 8'($urandom));
    send_byte({1'b0, KEY_LSHIFT}, 1'b0, 8'($urandom));
    send_byte(8'h1E, 1'b0, 8'($urandom));
    send_byte({1'b1, KEY_LSHIFT}, 1'b0, 8'($urandom));
    send_byte({1'b0, KEY_CAPS}, 1'b0, 8'($urandom));
    send_byte({1'b0, KEY_NUM}, 1'b0, 8'($urandom));
    send_byte({1'b0, KEY_PAD_LO}, 1'b0, 8'($urandom));
    send_byte({1'b0, KEY_INS}, 1'b0, 8'($urandom));
    send_byte({1'b0, KEY_ALT}, 1'b0, 8'($urandom));
    send_byte({1'b0, KEY_DEL}, 1'b0, 8'($urandom));
    send_byte({1'b1, KEY_ALT}, 1'b0, 8'($urandom));

    // Random part in four phases of idling: none, sender, receiver, both.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin gap_pct = 0;  stall_pct = 0;  end
        1:       begin gap_pct = 50; stall_pct = 0;  end
        2:       begin gap_pct = 0;  stall_pct = 50; end
        default: begin gap_pct = 12; stall_pct = 12; end
      endcase
      phase_end = bytes_sent + RANDOM_BYTES / 4;
      while (bytes_sent < phase_end) random_gesture();
    end
    in_valid <= 1'b0;

    while (words_pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[keyboard_scancode_translator_top.f]
hdl/kst_pkg.sv
hdl/kst_xlate.sv
hdl/keyboard_scancode_translator_top.sv
hdl/kst_checker.sv
dv/keyboard_scancode_translator_checker.sv
dv/keyboard_scancode_translator_top_test.sv
